/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every cycle outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, also checked while reset is asserted.
`define ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/mwpf_pkg.sv */
// Package: shared constants and types of the pseudoforest engine.
`default_nettype none
package mwpf_pkg;
    localparam int MAX_NODES = 1024;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int WEIGHT_W  = 32;
    localparam int TOTAL_W   = 42;
    localparam logic [CNT_W-1:0] NODE_LIMIT = CNT_W'(MAX_NODES);
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    typedef struct packed {
        logic                op;
        logic [IDX_W-1:0]    a;
        logic [IDX_W-1:0]    b;
        logic [WEIGHT_W-1:0] w;
        logic                ord_err;
        logic                rng_err;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] link;
        logic [CNT_W-1:0] nodes;
        logic [CNT_W-1:0] edges;
    } t_node;
endpackage
`default_nettype wire

/* rtl/max_weight_pseudoforest_union_find.sv */
// Top level of the greedy maximum-weight pseudoforest engine.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  command  | in        | start & !busy      | i_operation, i_endpoint_a/b, i_edge_weight
//  result   | out       | o_done (1 cycle)   | o_accepted, o_running_total, o_*_error
//  config   | in        | i_cfg_we           | i_cfg_wdata (node_count)
//
// Flow: an edge runs a root walk from each endpoint (the root included) and a
// compression walk along each path, with a read and a check state per node visited,
// since the node RAM has a single read port; then merge and result. A range error is
// answered from idle without a walk; a clear rewrites every node RAM entry.
// Reset: synchronous, active low; afterwards a sweep initializes every entry of the
// node RAM, and busy stays high during it.
// Stalls: the receiver cannot stall; busy also rises when the two-entry queue fills.
`default_nettype none
module max_weight_pseudoforest_union_find (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire                               i_operation,
    input  wire [mwpf_pkg::IDX_W-1:0]         i_endpoint_a,
    input  wire [mwpf_pkg::IDX_W-1:0]         i_endpoint_b,
    input  wire [mwpf_pkg::WEIGHT_W-1:0]      i_edge_weight,
    input  wire                               i_cfg_we,
    input  wire [mwpf_pkg::CNT_W-1:0]         i_cfg_wdata,
    output logic                              o_done,
    output logic                              o_accepted,
    output logic [mwpf_pkg::TOTAL_W-1:0]      o_running_total,
    output logic                              o_order_error,
    output logic                              o_range_error
);
    mwpf_pkg::t_item front_item;
    mwpf_pkg::t_item head_item;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    logic            init;

    // Transfer in when the queue has room and the reset sweep is over
    assign busy = full | init;
    assign push = start & ~busy;

    mwpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (push),
        .i_operation  (i_operation),
        .i_endpoint_a (i_endpoint_a),
        .i_endpoint_b (i_endpoint_b),
        .i_edge_weight(i_edge_weight),
        .o_item       (front_item)
    );

    // Hold classified items until the engine is free
    mwpf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (front_item),
        .i_pop  (pop),
        .o_item (head_item),
        .o_full (full),
        .o_empty(empty)
    );

    mwpf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_item         (head_item),
        .o_pop          (pop),
        .o_init         (init),
        .o_done         (o_done),
        .o_accepted     (o_accepted),
        .o_running_total(o_running_total),
        .o_order_error  (o_order_error),
        .o_range_error  (o_range_error)
    );
endmodule
`default_nettype wire

/* rtl/mwpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mwpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/mwpf_front.sv */
// Front end: node limit register, weight order and range classification.
`default_nettype none
module mwpf_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [mwpf_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  wire                          i_push,
    input  wire                          i_operation,
    input  wire [mwpf_pkg::IDX_W-1:0]    i_endpoint_a,
    input  wire [mwpf_pkg::IDX_W-1:0]    i_endpoint_b,
    input  wire [mwpf_pkg::WEIGHT_W-1:0] i_edge_weight,
    output mwpf_pkg::t_item              o_item
);
    logic [mwpf_pkg::CNT_W-1:0]    r_node_count;
    logic [mwpf_pkg::WEIGHT_W-1:0] r_prev;
    logic [mwpf_pkg::CNT_W-1:0]    limit;

    always_comb begin
        limit = (r_node_count > mwpf_pkg::NODE_LIMIT) ? mwpf_pkg::NODE_LIMIT : r_node_count;
        o_item.op      = i_operation;
        o_item.a       = i_endpoint_a;
        o_item.b       = i_endpoint_b;
        o_item.w       = i_edge_weight;
        o_item.ord_err = (i_operation == mwpf_pkg::OP_EDGE) && (i_edge_weight > r_prev);
        o_item.rng_err = (i_operation == mwpf_pkg::OP_EDGE) &&
                         (({1'b0, i_endpoint_a} >= limit) || ({1'b0, i_endpoint_b} >= limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= mwpf_pkg::NODE_LIMIT;
            r_prev       <= '1;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (i_push) begin
                r_prev <= (i_operation == mwpf_pkg::OP_EDGE) ? i_edge_weight : '1;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/mwpf_queue.sv */
// Two-entry queue between front end and union-find engine.
`default_nettype none
module mwpf_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  mwpf_pkg::t_item i_item,
    input  wire             i_pop,
    output mwpf_pkg::t_item o_item,
    output logic            o_full,
    output logic            o_empty
);
    mwpf_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

/* rtl/mwpf_back.sv */
// Back end: union-find engine with root walks, path compression, merge and clear sweep.
`default_nettype none
module mwpf_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_empty,
    input  mwpf_pkg::t_item             i_item,
    output logic                        o_pop,
    output logic                        o_init,
    output logic                        o_done,
    output logic                        o_accepted,
    output logic [mwpf_pkg::TOTAL_W-1:0] o_running_total,
    output logic                        o_order_error,
    output logic                        o_range_error
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_CRD  = 4'd4;
    localparam logic [3:0] S_CCHK = 4'd5;
    localparam logic [3:0] S_UPD1 = 4'd6;
    localparam logic [3:0] S_UPD2 = 4'd7;

    localparam int IW = mwpf_pkg::IDX_W;
    localparam int CW = mwpf_pkg::CNT_W;

    logic [3:0]   r_state, n_state;
    logic [IW-1:0] r_addr, n_addr;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_x, n_x;
    logic [IW-1:0] r_ra, n_ra;
    logic [IW-1:0] r_rb, n_rb;
    logic [CW-1:0] r_na, n_na, r_ea, n_ea, r_nb, n_nb, r_eb, n_eb;
    logic          r_phase, n_phase;
    mwpf_pkg::t_item r_item, n_item;
    logic [mwpf_pkg::TOTAL_W-1:0] r_total, n_total;
    logic          r_clr_emit, n_clr_emit;
    logic          r_init, n_init;
    logic          r_done, n_done;
    logic          r_acc, n_acc;
    logic          r_ord, n_ord;
    logic          r_rng, n_rng;

    logic          we;
    logic [IW-1:0] waddr;
    mwpf_pkg::t_node wdata;
    logic [IW-1:0] raddr;
    logic [$bits(mwpf_pkg::t_node)-1:0] rdata_raw;
    mwpf_pkg::t_node rdata;
    logic [IW-1:0] root;

    mwpf_ram #(
        .WIDTH($bits(mwpf_pkg::t_node)),
        .DEPTH(mwpf_pkg::MAX_NODES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );

    assign rdata = mwpf_pkg::t_node'(rdata_raw);
    assign root  = r_phase ? r_rb : r_ra;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_cur      = r_cur;
        n_x        = r_x;
        n_ra       = r_ra;
        n_rb       = r_rb;
        n_na       = r_na;
        n_ea       = r_ea;
        n_nb       = r_nb;
        n_eb       = r_eb;
        n_phase    = r_phase;
        n_item     = r_item;
        n_total    = r_total;
        n_clr_emit = r_clr_emit;
        n_init     = r_init;
        n_done     = 1'b0;
        n_acc      = r_acc;
        n_ord      = r_ord;
        n_rng      = r_rng;
        o_pop      = 1'b0;
        we         = 1'b0;
        waddr      = r_cur;
        wdata      = '0;
        raddr      = r_cur;
        case (r_state)
            S_CLR: begin
                we          = 1'b1;
                waddr       = r_addr;
                wdata.link  = r_addr;
                wdata.nodes = CW'(1);
                wdata.edges = '0;
                n_addr      = r_addr + IW'(1);
                if (r_addr == IW'(mwpf_pkg::MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                    n_init  = 1'b0;
                    if (r_clr_emit) begin
                        n_done = 1'b1;
                        n_acc  = 1'b0;
                        n_ord  = 1'b0;
                        n_rng  = 1'b0;
                    end
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    if (i_item.op == mwpf_pkg::OP_CLEAR) begin
                        n_total    = '0;
                        n_addr     = '0;
                        n_clr_emit = 1'b1;
                        n_state    = S_CLR;
                    end else if (i_item.rng_err) begin
                        n_done = 1'b1;
                        n_acc  = 1'b0;
                        n_ord  = i_item.ord_err;
                        n_rng  = 1'b1;
                    end else begin
                        n_cur   = i_item.a;
                        n_x     = i_item.a;
                        n_phase = 1'b0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                // Root reached when the entry points to itself
                if (rdata.link == r_cur) begin
                    if (r_phase) begin
                        n_rb = r_cur;
                        n_nb = rdata.nodes;
                        n_eb = rdata.edges;
                    end else begin
                        n_ra = r_cur;
                        n_na = rdata.nodes;
                        n_ea = rdata.edges;
                    end
                    n_cur   = r_x;
                    n_state = S_CRD;
                end else begin
                    n_cur   = rdata.link;
                    n_state = S_RD;
                end
            end
            S_CRD: begin
                n_state = S_CCHK;
            end
            S_CCHK: begin
                if (rdata.link == root) begin
                    if (r_phase) begin
                        n_state = S_UPD1;
                    end else begin
                        n_phase = 1'b1;
                        n_cur   = r_item.b;
                        n_x     = r_item.b;
                        n_state = S_RD;
                    end
                end else begin
                    // Point this node straight at the root, advance along the path
                    we          = 1'b1;
                    waddr       = r_cur;
                    wdata.link  = root;
                    wdata.nodes = rdata.nodes;
                    wdata.edges = rdata.edges;
                    n_cur       = rdata.link;
                    n_state     = S_CRD;
                end
            end
            S_UPD1: begin
                n_acc   = 1'b0;
                n_state = S_UPD2;
                waddr   = r_ra;
                if (r_ra == r_rb) begin
                    if (r_ea < r_na) begin
                        we          = 1'b1;
                        wdata.link  = r_ra;
                        wdata.nodes = r_na;
                        wdata.edges = r_ea + CW'(1);
                        n_acc       = 1'b1;
                    end
                end else if ((r_ea < r_na) || (r_eb < r_nb)) begin
                    we          = 1'b1;
                    wdata.link  = r_rb;
                    wdata.nodes = r_na;
                    wdata.edges = r_ea;
                    n_acc       = 1'b1;
                end
                if (n_acc) begin
                    n_total = r_total + {{(mwpf_pkg::TOTAL_W - mwpf_pkg::WEIGHT_W){1'b0}},
                                         r_item.w};
                end
            end
            S_UPD2: begin
                waddr = r_rb;
                if (r_acc && (r_ra != r_rb)) begin
                    we          = 1'b1;
                    wdata.link  = r_rb;
                    wdata.nodes = r_nb + r_na;
                    wdata.edges = r_eb + r_ea + CW'(1);
                end
                n_done  = 1'b1;
                n_ord   = r_item.ord_err;
                n_rng   = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_x     <= n_x;
        r_ra    <= n_ra;
        r_rb    <= n_rb;
        r_na    <= n_na;
        r_ea    <= n_ea;
        r_nb    <= n_nb;
        r_eb    <= n_eb;
        r_item  <= n_item;
        r_acc   <= n_acc;
        r_ord   <= n_ord;
        r_rng   <= n_rng;
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_addr     <= '0;
            r_phase    <= 1'b0;
            r_total    <= '0;
            r_clr_emit <= 1'b0;
            r_init     <= 1'b1;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_phase    <= n_phase;
            r_total    <= n_total;
            r_clr_emit <= n_clr_emit;
            r_init     <= n_init;
            r_done     <= n_done;
        end
    end

    assign o_init          = r_init;
    assign o_done          = r_done;
    assign o_accepted      = r_acc;
    assign o_running_total = r_total;
    assign o_order_error   = r_ord;
    assign o_range_error   = r_rng;
endmodule
`default_nettype wire

/* rtl/mwpf_checker.sv */
// Port-level checker for the pseudoforest engine, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module mwpf_port_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire busy,
    input wire o_done,
    input wire o_accepted,
    input wire o_range_error
);
    `ASSERT_IMPLY(a_rng_rejects, i_clk, i_rst_n, o_done && o_range_error, !o_accepted)
    `ASSERT_NEXT(a_rst_quiet, i_clk, !i_rst_n, !o_done)
    `ASSERT_NEXT(a_rst_busy, i_clk, !i_rst_n, busy)
endmodule

bind max_weight_pseudoforest_union_find mwpf_port_checker u_mwpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_done       (o_done),
    .o_accepted   (o_accepted),
    .o_range_error(o_range_error)
);
`default_nettype wire
